@@ rtl/ddgo_pkg.sv @@
// Shared types, constants and the program table of the gyro odometry block.
package ddgo_pkg;

    // Fixed-point constants (Q2.30 trigonometry, Q16.16 arc)
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [31:0] Q30_ONE = 32'd1073741824;
    localparam logic [32:0] ARC_MAX = 33'h1_FFFF_FFFF;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_WB_ARC,
        OP_WB_ANG,
        OP_WB_SQ,
        OP_WB_N,
        OP_WB_Q,
        OP_FIX,
        OP_WB_CHORD,
        OP_WB_SIN,
        OP_WB_DX,
        OP_WB_DY,
        OP_POSE,
        OP_POLY
    } op_t;

    // Multiplier operand A sources
    typedef enum logic [2:0] {
        ASEL_SMAG,
        ASEL_DMAG,
        ASEL_ANG,
        ASEL_ARC,
        ASEL_ROCT,
        ASEL_CHORD,
        ASEL_SQ,
        ASEL_N
    } asel_t;

    // Multiplier operand B sources
    typedef enum logic [2:0] {
        BSEL_SCALE,
        BSEL_PI,
        BSEL_ANG,
        BSEL_T,
        BSEL_COS,
        BSEL_SIN,
        BSEL_RECIP
    } bsel_t;

    // Coefficient sets: sinc uses entries 0..4, cosine 5..9
    localparam logic [3:0] KBASE_SINC = 4'd0;
    localparam logic [3:0] KBASE_COS  = 4'd5;

    typedef struct packed {
        op_t        kind;
        asel_t      a_sel;
        bsel_t      b_sel;
        logic [3:0] kidx;
    } cmd_t;

    typedef struct packed {
        logic out_hold;
    } status_t;

    // Horner divisor
    function automatic logic [6:0] k_val(input logic [3:0] idx);
        logic [6:0] v;
        case (idx)
            4'd0: v = 7'd110;
            4'd1: v = 7'd72;
            4'd2: v = 7'd42;
            4'd3: v = 7'd20;
            4'd4: v = 7'd6;
            4'd5: v = 7'd90;
            4'd6: v = 7'd56;
            4'd7: v = 7'd30;
            4'd8: v = 7'd12;
            4'd9: v = 7'd2;
            default: v = 7'd1;
        endcase
        return v;
    endfunction

    // Half of the divisor, added before division for rounding
    function automatic logic [5:0] k_half(input logic [3:0] idx);
        logic [5:0] v;
        case (idx)
            4'd0: v = 6'd55;
            4'd1: v = 6'd36;
            4'd2: v = 6'd21;
            4'd3: v = 6'd10;
            4'd4: v = 6'd3;
            4'd5: v = 6'd45;
            4'd6: v = 6'd28;
            4'd7: v = 6'd15;
            4'd8: v = 6'd6;
            4'd9: v = 6'd1;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

    // floor(2^32 / k): estimate is exact or one low for dividends below 2^32
    function automatic logic [31:0] k_recip(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0: v = 32'd39045157;
            4'd1: v = 32'd59652323;
            4'd2: v = 32'd102261126;
            4'd3: v = 32'd214748364;
            4'd4: v = 32'd715827882;
            4'd5: v = 32'd47721858;
            4'd6: v = 32'd76695844;
            4'd7: v = 32'd143165576;
            4'd8: v = 32'd357913941;
            4'd9: v = 32'd2147483648;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic cmd_t mk(input op_t k, input asel_t a, input bsel_t b,
                                input logic [3:0] ki);
        cmd_t c;
        c.kind  = k;
        c.a_sel = a;
        c.b_sel = b;
        c.kidx  = ki;
        return c;
    endfunction

    localparam int PROG_LAST = 21;

    // Main program; OP_POLY runs five Horner steps in the sequencer
    function automatic cmd_t prog(input logic [4:0] pc);
        cmd_t c;
        case (pc)
            5'd0:  c = mk(OP_MUL,      ASEL_SMAG,  BSEL_SCALE, 4'd0);
            5'd1:  c = mk(OP_WB_ARC,   ASEL_SMAG,  BSEL_SCALE, 4'd0);
            5'd2:  c = mk(OP_MUL,      ASEL_DMAG,  BSEL_PI,    4'd0);
            5'd3:  c = mk(OP_WB_ANG,   ASEL_DMAG,  BSEL_PI,    4'd0);
            5'd4:  c = mk(OP_MUL,      ASEL_ANG,   BSEL_ANG,   4'd0);
            5'd5:  c = mk(OP_WB_SQ,    ASEL_ANG,   BSEL_ANG,   4'd0);
            5'd6:  c = mk(OP_POLY,     ASEL_SQ,    BSEL_T,     KBASE_SINC);
            5'd7:  c = mk(OP_MUL,      ASEL_ARC,   BSEL_T,     4'd0);
            5'd8:  c = mk(OP_WB_CHORD, ASEL_ARC,   BSEL_T,     4'd0);
            5'd9:  c = mk(OP_MUL,      ASEL_ROCT,  BSEL_PI,    4'd0);
            5'd10: c = mk(OP_WB_ANG,   ASEL_ROCT,  BSEL_PI,    4'd0);
            5'd11: c = mk(OP_MUL,      ASEL_ANG,   BSEL_ANG,   4'd0);
            5'd12: c = mk(OP_WB_SQ,    ASEL_ANG,   BSEL_ANG,   4'd0);
            5'd13: c = mk(OP_POLY,     ASEL_SQ,    BSEL_T,     KBASE_SINC);
            5'd14: c = mk(OP_MUL,      ASEL_ANG,   BSEL_T,     4'd0);
            5'd15: c = mk(OP_WB_SIN,   ASEL_ANG,   BSEL_T,     4'd0);
            5'd16: c = mk(OP_POLY,     ASEL_SQ,    BSEL_T,     KBASE_COS);
            5'd17: c = mk(OP_MUL,      ASEL_CHORD, BSEL_COS,   4'd0);
            5'd18: c = mk(OP_WB_DX,    ASEL_CHORD, BSEL_COS,   4'd0);
            5'd19: c = mk(OP_MUL,      ASEL_CHORD, BSEL_SIN,   4'd0);
            5'd20: c = mk(OP_WB_DY,    ASEL_CHORD, BSEL_SIN,   4'd0);
            5'd21: c = mk(OP_POSE,     ASEL_CHORD, BSEL_SIN,   4'd0);
            default: c = mk(OP_NOP,    ASEL_SMAG,  BSEL_SCALE, 4'd0);
        endcase
        return c;
    endfunction

endpackage

@@ rtl/ddgo_ctrl.sv @@
// Sequencer: walks the program and expands each polynomial into Horner steps.
module ddgo_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ddgo_pkg::status_t st,
    output ddgo_pkg::cmd_t   cmd
);
    import ddgo_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_POLY = 3'b100
    } state_t;

    typedef enum logic [2:0] {
        HS_MUL_XT,
        HS_WB_N,
        HS_MUL_RECIP,
        HS_WB_Q,
        HS_FIX
    } hstep_t;

    localparam logic [2:0] TERM_LAST = 3'd4;

    state_t      state_reg, state_next;
    logic [4:0]  pc_reg, pc_next;
    hstep_t      sub_reg, sub_next;
    logic [2:0]  it_reg, it_next;
    cmd_t        uop;
    logic [3:0]  kidx;

    assign uop  = prog(pc_reg);
    assign kidx = 4'(uop.kidx + {1'b0, it_reg});

    // Next state and command issue
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        sub_next   = sub_reg;
        it_next    = it_reg;
        in_stall   = 1'b1;
        cmd        = mk(OP_NOP, ASEL_SMAG, BSEL_SCALE, 4'd0);
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd        = mk(OP_LOAD, ASEL_SMAG, BSEL_SCALE, 4'd0);
                    pc_next    = 5'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (uop.kind == OP_POLY)
                begin
                    sub_next   = HS_MUL_XT;
                    it_next    = 3'd0;
                    state_next = ST_POLY;
                end
                else if (uop.kind == OP_POSE)
                begin
                    // hold the pose update while the last result is unread
                    if (!st.out_hold)
                    begin
                        cmd        = uop;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd     = uop;
                    pc_next = 5'(pc_reg + 5'd1);
                end
            end
            ST_POLY:
            begin
                case (sub_reg)
                    HS_MUL_XT:    cmd = mk(OP_MUL,  ASEL_SQ, BSEL_T,     kidx);
                    HS_WB_N:      cmd = mk(OP_WB_N, ASEL_SQ, BSEL_T,     kidx);
                    HS_MUL_RECIP: cmd = mk(OP_MUL,  ASEL_N,  BSEL_RECIP, kidx);
                    HS_WB_Q:      cmd = mk(OP_WB_Q, ASEL_N,  BSEL_RECIP, kidx);
                    HS_FIX:       cmd = mk(OP_FIX,  ASEL_N,  BSEL_RECIP, kidx);
                    default:      cmd = mk(OP_NOP,  ASEL_SQ, BSEL_T,     kidx);
                endcase
                if (sub_reg == HS_FIX)
                begin
                    sub_next = HS_MUL_XT;
                    if (it_reg == TERM_LAST)
                    begin
                        it_next    = 3'd0;
                        pc_next    = 5'(pc_reg + 5'd1);
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        it_next = 3'(it_reg + 3'd1);
                    end
                end
                else
                begin
                    sub_next = hstep_t'(3'(sub_reg + 3'd1));
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= 5'd0;
            sub_reg   <= HS_MUL_XT;
            it_reg    <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            sub_reg   <= sub_next;
            it_reg    <= it_next;
        end
    end

endmodule

@@ rtl/ddgo_dp.sv @@
// Datapath: deltas, shared multiplier, rounding write-back and pose update.
module ddgo_dp #(
    parameter int ANGLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ddgo_pkg::cmd_t     cmd,
    output ddgo_pkg::status_t  st,
    input  logic [23:0]        scale,
    input  logic signed [31:0] left_count,
    input  logic signed [31:0] right_count,
    input  logic [15:0]        gyro_heading,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [31:0] x_position,
    output logic signed [31:0] y_position,
    output logic [15:0]        heading,
    output logic               saturated
);
    import ddgo_pkg::*;

    localparam int AB = ANGLE_BITS;

    // Persistent state
    logic [31:0]        last_left_reg, last_right_reg;
    logic [AB-1:0]      last_gyro_reg, heading_reg;
    logic signed [31:0] pose_x_reg, pose_y_reg;
    logic [15:0]        out_heading_reg;
    logic               out_valid_reg, out_sat_reg;

    logic [31:0]        last_left_next, last_right_next;
    logic [AB-1:0]      last_gyro_next, heading_next;
    logic signed [31:0] pose_x_next, pose_y_next;
    logic [15:0]        out_heading_next;
    logic               out_valid_next, out_sat_next;

    // Per-request working registers
    logic               sum_neg_reg, sum_neg_next;
    logic [32:0]        smag_reg, smag_next;
    logic [AB-1:0]      dmag_reg, dmag_next;
    logic [AB:0]        phi_reg, phi_next;
    logic [32:0]        arc_reg, arc_next;
    logic               sat_reg, sat_next;
    logic [30:0]        ang_reg, ang_next;
    logic [31:0]        sq_reg, sq_next;
    logic [31:0]        t_reg, t_next;
    logic [31:0]        n_reg, n_next;
    logic [30:0]        q_reg, q_next;
    logic [32:0]        chord_reg, chord_next;
    logic [30:0]        s_reg, s_next;
    logic [32:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic [64:0]        prod_reg, prod_next;

    // Input deltas
    logic [31:0]    dl, dr;
    logic [32:0]    sum;
    logic [AB+15:0] gyro_ext;
    logic [AB-1:0]  gyro_a, draw;

    assign dl       = left_count - last_left_reg;
    assign dr       = right_count - last_right_reg;
    assign sum      = {dl[31], dl} + {dr[31], dr};
    assign gyro_ext = {{AB{1'b0}}, gyro_heading};
    assign gyro_a   = gyro_ext[AB-1:0];
    assign draw     = gyro_a - last_gyro_reg;

    // Octant reduction of the projection angle
    logic [2:0]    oct;
    logic [AB-3:0] rraw;
    logic [AB-2:0] roct;
    logic          swap, cneg, sneg;

    assign oct  = phi_reg[AB:AB-2];
    assign rraw = phi_reg[AB-3:0];
    assign roct = oct[0] ? ((AB-1)'(1) << (AB-2)) - {1'b0, rraw} : {1'b0, rraw};
    assign swap = oct inside {3'd1, 3'd2, 3'd5, 3'd6};
    assign cneg = oct inside {[3'd2:3'd5]};
    assign sneg = oct[2];

    logic [31:0] cos_sel, sin_sel;
    assign cos_sel = swap ? {1'b0, s_reg} : t_reg;
    assign sin_sel = swap ? t_reg : {1'b0, s_reg};

    // Shared multiplier operands
    logic [32:0] op_a;
    logic [31:0] op_b;

    always_comb
    begin
        case (cmd.a_sel)
            ASEL_SMAG:  op_a = smag_reg;
            ASEL_DMAG:  op_a = 33'(dmag_reg);
            ASEL_ANG:   op_a = 33'(ang_reg);
            ASEL_ARC:   op_a = arc_reg;
            ASEL_ROCT:  op_a = 33'(roct);
            ASEL_CHORD: op_a = chord_reg;
            ASEL_SQ:    op_a = 33'(sq_reg);
            ASEL_N:     op_a = 33'(n_reg);
            default:    op_a = 33'd0;
        endcase
        case (cmd.b_sel)
            BSEL_SCALE: op_b = 32'(scale);
            BSEL_PI:    op_b = PI_Q30;
            BSEL_ANG:   op_b = 32'(ang_reg);
            BSEL_T:     op_b = t_reg;
            BSEL_COS:   op_b = cos_sel;
            BSEL_SIN:   op_b = sin_sel;
            BSEL_RECIP: op_b = k_recip(cmd.kidx);
            default:    op_b = 32'd0;
        endcase
    end

    // Rounded views of the product
    logic [64:0] rnd30, rnd_ang, rnd8;
    assign rnd30   = prod_reg + 65'(Q30_ONE >> 1);
    assign rnd_ang = prod_reg + (65'(1) << (AB-1));
    assign rnd8    = prod_reg + 65'd128;

    // Quotient correction for the Horner divide
    logic [6:0]  kv;
    logic [37:0] qk, remn;
    logic [31:0] qc;
    assign kv   = k_val(cmd.kidx);
    assign qk   = 38'(q_reg) * 38'(kv);
    assign remn = 38'(n_reg) - qk;
    assign qc   = (remn >= 38'(kv)) ? 32'(q_reg) + 32'd1 : 32'(q_reg);

    // Pose accumulation with clipping
    logic signed [34:0] xsum, ysum, xadd, yadd;
    assign xadd = (sum_neg_reg ^ cneg) ? -$signed({2'b0, dx_reg}) : $signed({2'b0, dx_reg});
    assign yadd = (sum_neg_reg ^ sneg) ? -$signed({2'b0, dy_reg}) : $signed({2'b0, dy_reg});
    assign xsum = 35'(pose_x_reg) + xadd;
    assign ysum = 35'(pose_y_reg) + yadd;

    localparam logic signed [34:0] POS_MAX = 35'sd2147483647;
    localparam logic signed [34:0] POS_MIN = -35'sd2147483648;

    logic [AB+15:0] head_ext;
    assign head_ext = {16'b0, heading_reg};

    always_comb
    begin
        last_left_next   = last_left_reg;
        last_right_next  = last_right_reg;
        last_gyro_next   = last_gyro_reg;
        heading_next     = heading_reg;
        pose_x_next      = pose_x_reg;
        pose_y_next      = pose_y_reg;
        out_heading_next = out_heading_reg;
        out_sat_next     = out_sat_reg;
        out_valid_next   = out_valid_reg && out_stall;
        sum_neg_next     = sum_neg_reg;
        smag_next        = smag_reg;
        dmag_next        = dmag_reg;
        phi_next         = phi_reg;
        arc_next         = arc_reg;
        sat_next         = sat_reg;
        ang_next         = ang_reg;
        sq_next          = sq_reg;
        t_next           = t_reg;
        n_next           = n_reg;
        q_next           = q_reg;
        chord_next       = chord_reg;
        s_next           = s_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        prod_next        = prod_reg;
        case (cmd.kind)
            OP_LOAD:
            begin
                // take the deltas and advance the heading
                sum_neg_next    = sum[32];
                smag_next       = sum[32] ? 33'(-sum) : sum;
                dmag_next       = draw[AB-1] ? AB'(-draw) : draw;
                phi_next        = {heading_reg, 1'b0} + {draw[AB-1], draw};
                heading_next    = heading_reg + draw;
                last_left_next  = left_count;
                last_right_next = right_count;
                last_gyro_next  = gyro_a;
                sat_next        = 1'b0;
            end
            OP_MUL:
            begin
                prod_next = 65'(op_a) * 65'(op_b);
            end
            OP_WB_ARC:
            begin
                // clip a huge arc before projection
                if (rnd8[64:41] != '0)
                begin
                    arc_next = ARC_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    arc_next = rnd8[40:8];
                end
            end
            OP_WB_ANG:
            begin
                ang_next = rnd_ang[AB+30:AB];
            end
            OP_WB_SQ:
            begin
                sq_next = rnd30[61:30];
                t_next  = Q30_ONE;
            end
            OP_WB_N:
            begin
                n_next = rnd30[61:30] + 32'(k_half(cmd.kidx));
            end
            OP_WB_Q:
            begin
                q_next = prod_reg[62:32];
            end
            OP_FIX:
            begin
                t_next = (qc >= Q30_ONE) ? 32'd0 : Q30_ONE - qc;
            end
            OP_WB_CHORD:
            begin
                chord_next = rnd30[62:30];
            end
            OP_WB_SIN:
            begin
                s_next = rnd30[60:30];
                t_next = Q30_ONE;
            end
            OP_WB_DX:
            begin
                dx_next = rnd30[62:30];
            end
            OP_WB_DY:
            begin
                dy_next = rnd30[62:30];
            end
            OP_POSE:
            begin
                // commit the pose and load the result
                if (xsum > POS_MAX)
                begin
                    pose_x_next = 32'sh7FFF_FFFF;
                end
                else if (xsum < POS_MIN)
                begin
                    pose_x_next = -32'sh8000_0000;
                end
                else
                begin
                    pose_x_next = xsum[31:0];
                end
                if (ysum > POS_MAX)
                begin
                    pose_y_next = 32'sh7FFF_FFFF;
                end
                else if (ysum < POS_MIN)
                begin
                    pose_y_next = -32'sh8000_0000;
                end
                else
                begin
                    pose_y_next = ysum[31:0];
                end
                out_sat_next = sat_reg || (xsum > POS_MAX) || (xsum < POS_MIN)
                               || (ysum > POS_MAX) || (ysum < POS_MIN);
                out_heading_next = head_ext[15:0];
                out_valid_next   = 1'b1;
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    // Pose and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg   <= '0;
            last_right_reg  <= '0;
            last_gyro_reg   <= '0;
            heading_reg     <= '0;
            pose_x_reg      <= '0;
            pose_y_reg      <= '0;
            out_heading_reg <= '0;
            out_sat_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            last_left_reg   <= last_left_next;
            last_right_reg  <= last_right_next;
            last_gyro_reg   <= last_gyro_next;
            heading_reg     <= heading_next;
            pose_x_reg      <= pose_x_next;
            pose_y_reg      <= pose_y_next;
            out_heading_reg <= out_heading_next;
            out_sat_reg     <= out_sat_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        sum_neg_reg <= sum_neg_next;
        smag_reg    <= smag_next;
        dmag_reg    <= dmag_next;
        phi_reg     <= phi_next;
        arc_reg     <= arc_next;
        sat_reg     <= sat_next;
        ang_reg     <= ang_next;
        sq_reg      <= sq_next;
        t_reg       <= t_next;
        n_reg       <= n_next;
        q_reg       <= q_next;
        chord_reg   <= chord_next;
        s_reg       <= s_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        prod_reg    <= prod_next;
    end

    assign st.out_hold = out_valid_reg && out_stall;
    assign out_valid   = out_valid_reg;
    assign x_position  = pose_x_reg;
    assign y_position  = pose_y_reg;
    assign heading     = out_heading_reg;
    assign saturated   = out_sat_reg;

endmodule

@@ rtl/diff_drive_gyro_odometry.sv @@
// Top level of the gyro-aided differential drive odometry block.
//
//   channel  direction  handshake            payload
//   in       request in in_valid / in_stall   left_count, right_count, gyro_heading
//   out      result out out_valid / out_stall x_position, y_position, heading, saturated
//   cfg      APB write  psel / penable        distance_scale at byte address 0
//
// The load runs at the edge that accepts the request, then 19 plain program
// steps run on the single shared 33x32 multiplier, along with three polynomials,
// each a dispatch step and five Horner terms (multiply, round, reciprocal
// multiply, quotient, correction). A new request is taken in the cycle after the
// pose commits, so only one request is in flight at a time; the pose commit waits
// while an earlier result is still stalled at the output.
// Reset clears the pose, the previous readings and the output valid.
module diff_drive_gyro_odometry #(
    parameter int ANGLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] left_count,
    input  logic signed [31:0] right_count,
    input  logic [15:0]        gyro_heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] x_position,
    output logic signed [31:0] y_position,
    output logic [15:0]        heading,
    output logic               saturated
);
    import ddgo_pkg::*;

    localparam logic       REG_DISTANCE_SCALE = 1'b0;
    localparam logic [23:0] SCALE_RESET       = 24'd195225;

    logic [23:0] scale_reg;
    logic        cfg_wr;
    cmd_t        cmd;
    status_t     st;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DISTANCE_SCALE);
    assign prdata = (paddr[2] == REG_DISTANCE_SCALE) ? {8'b0, scale_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_wr)
        begin
            scale_reg <= pwdata[23:0];
        end
    end

    ddgo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    ddgo_dp #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .scale        (scale_reg),
        .left_count   (left_count),
        .right_count  (right_count),
        .gyro_heading (gyro_heading),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .x_position   (x_position),
        .y_position   (y_position),
        .heading      (heading),
        .saturated    (saturated)
    );

    // One request in flight at a time
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in flight");

    // A fresh result appears together with readiness for the next request
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result raised while the sequencer is busy");

    // Results only change when the pose commits
    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && $past(rst_n)) |-> ($stable(x_position) && $stable(y_position)
                                         && $stable(heading)))
        else $error("result changed while busy");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the gyro-aided differential drive odometry block.
`timescale 1ns / 100ps

module tb_top;
    import ddgo_pkg::*;

    localparam logic [2:0] ADDR_SCALE  = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;
    localparam int         N_RANDOM    = 536;
    localparam logic [63:0] PI_VAL     = 64'd3373259426;
    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
    localparam logic [63:0] ARC_LIMIT  = (64'd1 << 33) - 1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        h;
        logic               sat;
    } pose_t;

    typedef struct {
        logic [31:0] l;
        logic [31:0] r;
        logic [15:0] g;
        bit          typed;
        pose_t       want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] left_count = '0, right_count = '0;
    logic [15:0] gyro_heading = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] x_position, y_position;
    logic [15:0] heading;
    logic saturated;

    // Shadow state of the odometry
    logic [23:0] odo_scale = 24'd195225;
    logic [31:0] prev_left = '0, prev_right = '0;
    logic [15:0] prev_gyro = '0, pose_head = '0;
    longint      pose_xs = 0, pose_ys = 0;

    pose_t pose_fifo[$];
    int    err_count = 0;
    bit    no_idle = 1'b0;

    diff_drive_gyro_odometry u_top (.*);

    // Clock: 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Fixed-point helpers
    function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (ONE_Q30 >> 1)) >> 30;
    endfunction

    function automatic logic [63:0] horner_step(input logic [63:0] x, input logic [63:0] t,
                                                input logic [63:0] k);
        logic [63:0] p;
        p = (x * t + (ONE_Q30 >> 1)) >> 30;
        p = (p + k / 2) / k;
        return (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
    endfunction

    function automatic logic [63:0] sinc_val(input logic [63:0] a);
        logic [63:0] x, t;
        x = mul_q(a, a);
        t = horner_step(x, ONE_Q30, 110);
        t = horner_step(x, t, 72);
        t = horner_step(x, t, 42);
        t = horner_step(x, t, 20);
        return horner_step(x, t, 6);
    endfunction

    function automatic logic [63:0] cos_val(input logic [63:0] a);
        logic [63:0] x, t;
        x = mul_q(a, a);
        t = horner_step(x, ONE_Q30, 90);
        t = horner_step(x, t, 56);
        t = horner_step(x, t, 30);
        t = horner_step(x, t, 12);
        return horner_step(x, t, 2);
    endfunction

    function automatic longint clip_pos(input longint v, inout bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Advance the shadow pose by one request and return the expected result
    function automatic pose_t odo_advance(input logic [31:0] l, input logic [31:0] r,
                                          input logic [15:0] g);
        logic [31:0] dl, dr;
        longint      sum;
        bit          neg, dneg, sat, sneg, cneg;
        logic [63:0] smag, arc, dmag, ahalf, chord, ang, s, c, tmp, dx, dy, rr;
        logic [15:0] draw;
        logic [16:0] phi;
        int          oct;
        pose_t       res;
        dl = l - prev_left;
        dr = r - prev_right;
        sum = longint'($signed(dl)) + longint'($signed(dr));
        neg = sum < 0;
        smag = neg ? -sum : sum;
        arc = (smag * odo_scale + 128) >> 8;
        draw = g - prev_gyro;
        dneg = draw[15];
        dmag = dneg ? 64'd65536 - draw : draw;
        sat = 1'b0;
        if (arc > ARC_LIMIT)
        begin
            arc = ARC_LIMIT;
            sat = 1'b1;
        end
        ahalf = (dmag * PI_VAL + 32768) >> 16;
        chord = mul_q(arc, sinc_val(ahalf));
        phi = {pose_head, 1'b0} + {1'b0, draw} + (dneg ? 17'h10000 : 17'h0);
        oct = phi[16:14];
        rr = phi[13:0];
        if (oct % 2 == 1)
            rr = 64'd16384 - rr;
        ang = (rr * PI_VAL + 32768) >> 16;
        s = mul_q(ang, sinc_val(ang));
        c = cos_val(ang);
        if (((oct + 1) & 2) != 0)
        begin
            tmp = s;
            s = c;
            c = tmp;
        end
        sneg = oct >= 4;
        cneg = oct >= 2 && oct <= 5;
        dx = mul_q(chord, c);
        dy = mul_q(chord, s);
        pose_xs = clip_pos(pose_xs + ((neg != cneg) ? -longint'(dx) : longint'(dx)), sat);
        pose_ys = clip_pos(pose_ys + ((neg != sneg) ? -longint'(dy) : longint'(dy)), sat);
        pose_head = pose_head + draw;
        prev_left = l;
        prev_right = r;
        prev_gyro = g;
        res.x = pose_xs[31:0];
        res.y = pose_ys[31:0];
        res.h = pose_head;
        res.sat = sat;
        return res;
    endfunction

    // Register write over the APB port; only index 0 exists
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_SCALE)
            odo_scale = data[23:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Let the block drain before touching the register
    task automatic drain;
        while (pose_fifo.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Send one request, with random idle before it; called at a falling edge
    task automatic send_request(input logic [31:0] l, input logic [31:0] r,
                                input logic [15:0] g, input bit typed, input pose_t want);
        pose_t p;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 37)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        left_count <= l;
        right_count <= r;
        gyro_heading <= g;
        do
            @(posedge clk);
        while (in_stall);
        p = odo_advance(l, r, g);
        pose_fifo.push_back(typed ? want : p);
        @(negedge clk);
    endtask

    // Receiver stall
    always @(negedge clk)
        out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 37);

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        pose_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pose_fifo.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result x=%h y=%h h=%h sat=%b",
                             x_position, y_position, heading, saturated);
            end
            else
            begin
                w = pose_fifo.pop_front();
                if (w.x !== x_position || w.y !== y_position || w.h !== heading
                    || w.sat !== saturated)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: want x=%h y=%h h=%h sat=%b, got x=%h y=%h h=%h sat=%b",
                                 w.x, w.y, w.h, w.sat,
                                 x_position, y_position, heading, saturated);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        row_t  rows[14];
        pose_t none;
        logic [31:0] l, r;
        logic [15:0] g;
        logic [31:0] scales[5];
        none = '0;
        rows[0]  = '{32'h0, 32'h0, 16'h0, 1'b1, '{32'sh0, 32'sh0, 16'h0, 1'b0}};
        // huge arc clipped, drives X to the rail
        rows[1]  = '{32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0, 1'b1,
                     '{32'sh7FFFFFFF, 32'sh0, 16'h0, 1'b1}};
        rows[2]  = '{32'h80000000, 32'h80000000, 16'h0, 1'b0, none};
        // half turn with no travel
        rows[3]  = '{32'h80000000, 32'h80000000, 16'h8000, 1'b0, none};
        rows[4]  = '{32'h80000100, 32'h7FFFFF00, 16'h8000, 1'b0, none};
        rows[5]  = '{32'hFFFFFFFF, 32'h00000000, 16'hFFFF, 1'b0, none};
        rows[6]  = '{32'h00000000, 32'hFFFFFFFF, 16'h4000, 1'b0, none};
        rows[7]  = '{32'h00001000, 32'h00001000, 16'h4000, 1'b0, none};
        rows[8]  = '{32'h00001000, 32'h00003000, 16'hC000, 1'b0, none};
        rows[9]  = '{32'h80000000, 32'h80000000, 16'h8001, 1'b0, none};
        rows[10] = '{32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 1'b0, none};
        rows[11] = '{32'h55555555, 32'hAAAAAAAA, 16'h5555, 1'b0, none};
        rows[12] = '{32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 1'b0, none};
        rows[13] = '{32'h0, 32'h0, 16'h0, 1'b0, none};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table at the reset scale
        foreach (rows[i])
            send_request(rows[i].l, rows[i].r, rows[i].g, rows[i].typed, rows[i].want);
        in_valid <= 1'b0;

        // Random phases, one scale each, extremes included
        scales[0] = 32'h0;
        scales[1] = 32'hFFFFFF;
        scales[2] = $urandom_range(24'hFFFFFF);
        scales[3] = 32'd195225;
        scales[4] = $urandom;
        l = prev_left;
        r = prev_right;
        g = prev_gyro;
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            if (ph == 2)
                reg_write(ADDR_UNUSED, $urandom);
            reg_write(ADDR_SCALE, scales[ph]);
            // resend the last readings: a request with no travel and no turn
            if (ph == 3)
            begin
                send_request(l, r, g, 1'b0, none);
            end
            for (int n = 0; n < N_RANDOM / 5; n++)
            begin
                no_idle = (ph == 2);
                if ($urandom_range(99) < 12)
                begin
                    l = $urandom;
                    r = $urandom;
                    g = $urandom;
                end
                else
                begin
                    l = l + $urandom_range(3000) - 1500;
                    r = r + $urandom_range(3000) - 1500;
                    g = g + (($urandom_range(99) < 20) ? 16'd0
                                                       : 16'($urandom_range(4000)) - 16'd2000);
                end
                send_request(l, r, g, 1'b0, none);
            end
            in_valid <= 1'b0;
            no_idle = 1'b0;
        end

        drain();
        if (err_count == 0)
            $display("diff_drive_gyro_odometry test passed");
        else
            $display("diff_drive_gyro_odometry test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10000000;
        $display("diff_drive_gyro_odometry test failed");
        $finish;
    end

endmodule
